// ----- design/psl_pkg.sv -----
// Package with the types and constants shared by the sliding window limiter.
`timescale 1ns / 1ps
`default_nettype none
package psl_pkg;
    localparam int unsigned ADDR_W = 32;
    localparam int unsigned TIME_W = 32;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 31;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 2'd2;
    localparam logic OP_CHECK = 1'b0;
    localparam logic OP_RECORD = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SW_ENT,
        ST_SW_RD,
        ST_SW_CMP,
        ST_FIND,
        ST_TR_RD,
        ST_TR_CMP,
        ST_FREE,
        ST_APPEND,
        ST_OUT
    } t_state;
endpackage
`default_nettype wire

// ----- design/psl_stamp_ram.sv -----
// Timestamp memory with one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module psl_stamp_ram #(
    parameter int unsigned DEPTH = 1024,
    parameter int unsigned AW = 10
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_we,
    input  wire logic [AW-1:0]             i_waddr,
    input  wire logic [psl_pkg::TIME_W-1:0] i_wdata,
    input  wire logic [AW-1:0]             i_raddr,
    output logic      [psl_pkg::TIME_W-1:0] o_rdata
);
    import psl_pkg::*;
    logic [TIME_W-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ----- design/per_source_sliding_window_limiter_unit.sv -----
// Top level of the per-source sliding window request limiter.
// An accepted word goes straight to its result when limiting is off or no address
// is given; otherwise a table search and a trim of the stamps examined come before it.
// Worst case is a record of a new source into a full table: a search, a sweep, a second search.
// Throughput: one word at a time; the next word is accepted after the result is taken.
// Reset clears valid bits, sweep time and configuration; entry and stamp memories are kept.
`timescale 1ns / 1ps
`default_nettype none
module per_source_sliding_window_limiter_unit #(
    parameter int unsigned SOURCES = 64,
    parameter int unsigned MAX_REQ = 16,
    parameter int unsigned SWEEP_MS = 1000
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // op[0], source_addr[32:1], addr_present[33], now_ms[65:34], zeros[71:66]
    input  wire logic [71:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // limited[0], tracked[1], recent_count[6:2], zero[7]
    output logic [7:0]       m_axis_tdata,
    input  wire logic        i_cfg_we,
    input  wire logic [psl_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [psl_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import psl_pkg::*;
    localparam int unsigned EW = (SOURCES > 1) ? $clog2(SOURCES) : 1;
    localparam int unsigned HW = (MAX_REQ > 1) ? $clog2(MAX_REQ) : 1;
    localparam int unsigned CW = $clog2(MAX_REQ + 1);
    localparam int unsigned AW = EW + HW;
    localparam int unsigned MW = ADDR_W + HW + CW;
    localparam logic [EW-1:0] E_LAST = EW'(SOURCES - 1);
    localparam logic [HW-1:0] H_LAST = HW'(MAX_REQ - 1);
    localparam logic [CW-1:0] C_MAX = CW'(MAX_REQ);

    t_state r_state, n_state;
    logic r_en, n_en;
    logic [4:0] r_lim, n_lim;
    logic [30:0] r_win, n_win;
    logic [TIME_W-1:0] r_last, n_last;
    logic [SOURCES-1:0] r_valid, n_valid;
    logic [MW-1:0] r_ent [SOURCES];
    logic [MW-1:0] r_erd;
    logic r_op, n_op;
    logic [ADDR_W-1:0] r_addr, n_addr;
    logic [TIME_W-1:0] r_now, n_now;
    logic [EW-1:0] r_e, n_e;
    logic r_post, n_post; // sweep before a record
    logic [HW-1:0] r_h, n_h;
    logic [CW-1:0] r_c, n_c;
    logic [7:0] r_out, n_out;
    logic [ADDR_W-1:0] erd_tag;
    logic [HW-1:0] erd_h;
    logic [CW-1:0] erd_c;
    logic ewe;
    logic [MW-1:0] ewd;
    logic [TIME_W-1:0] rd;
    logic we;
    logic [AW-1:0] waddr;
    logic [TIME_W-1:0] span, age;
    logic old;
    logic [HW-1:0] h_nx;
    logic [31:0] tsum;
    logic [HW-1:0] tail;

    psl_stamp_ram #(.DEPTH(1 << AW), .AW(AW)) u_ram (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(r_now),
        .i_raddr({r_e, r_h}), .o_rdata(rd)
    );

    assign erd_c = r_erd[CW-1:0];
    assign erd_h = r_erd[CW +: HW];
    assign erd_tag = r_erd[CW+HW +: ADDR_W];
    assign span = (r_state == ST_SW_CMP) ? {r_win, 1'b0} : {1'b0, r_win};
    assign age = r_now - rd;
    assign old = age > span;
    assign h_nx = (r_h == H_LAST) ? '0 : r_h + 1'b1;
    assign tsum = 32'(r_h) + 32'(r_c);
    assign tail = (tsum >= 32'(MAX_REQ)) ? HW'(tsum - 32'(MAX_REQ)) : HW'(tsum);
    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = (r_state == ST_OUT);
    assign m_axis_tdata = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_en <= 1'b0;
            r_lim <= 5'd10;
            r_win <= 31'd60000;
            r_last <= '0;
            r_valid <= '0;
        end else begin
            r_state <= n_state;
            r_en <= n_en;
            r_lim <= n_lim;
            r_win <= n_win;
            r_last <= n_last;
            r_valid <= n_valid;
        end
        if (ewe) begin
            r_ent[r_e] <= ewd;
        end
        r_erd <= r_ent[n_e];
        r_op <= n_op; r_addr <= n_addr; r_now <= n_now; r_e <= n_e;
        r_post <= n_post; r_h <= n_h; r_c <= n_c;
        r_out <= n_out;
    end

    always_comb begin
        n_state = r_state; n_en = r_en; n_lim = r_lim; n_win = r_win;
        n_last = r_last; n_valid = r_valid; n_op = r_op; n_addr = r_addr;
        n_now = r_now; n_e = r_e; n_post = r_post;
        n_h = r_h; n_c = r_c; n_out = r_out;
        ewe = 1'b0; ewd = '0;
        we = 1'b0; waddr = {r_e, tail};
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ENABLE: n_en = i_cfg_data[0];
                CFG_LIMIT: n_lim = i_cfg_data[4:0];
                CFG_WINDOW: n_win = i_cfg_data;
                default: ;
            endcase
        end
        unique case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_op = s_axis_tdata[0];
                    n_addr = s_axis_tdata[32:1];
                    n_now = s_axis_tdata[65:34];
                    n_e = '0; n_post = 1'b0;
                    n_out = '0;
                    if (!r_en || !s_axis_tdata[33]) begin
                        n_state = ST_OUT;
                    end else if (s_axis_tdata[0] == OP_CHECK &&
                                 (s_axis_tdata[65:34] - r_last) >= TIME_W'(SWEEP_MS)) begin
                        n_last = s_axis_tdata[65:34];
                        n_state = ST_SW_ENT;
                    end else begin
                        n_state = ST_FIND;
                    end
                end
            end
            ST_SW_ENT: begin
                n_h = erd_h; n_c = erd_c;
                if (r_valid[r_e] && erd_c != '0) begin
                    n_state = ST_SW_RD;
                end else begin
                    n_valid[r_e] = 1'b0;
                    if (r_e == E_LAST) begin
                        n_e = '0;
                        n_state = r_post ? ST_FREE : ST_FIND;
                    end else begin
                        n_e = r_e + 1'b1;
                    end
                end
            end
            ST_SW_RD: n_state = ST_SW_CMP;
            ST_SW_CMP: begin
                if (old) begin
                    n_h = h_nx; n_c = r_c - 1'b1;
                end
                if (old && r_c != CW'(1)) begin
                    n_state = ST_SW_RD;
                end else begin
                    ewe = 1'b1;
                    ewd = {erd_tag, n_h, n_c};
                    if (old) begin
                        n_valid[r_e] = 1'b0;
                    end
                    if (r_e == E_LAST) begin
                        n_e = '0;
                        n_state = r_post ? ST_FREE : ST_FIND;
                    end else begin
                        n_e = r_e + 1'b1;
                        n_state = ST_SW_ENT;
                    end
                end
            end
            ST_FIND: begin
                if (r_valid[r_e] && erd_tag == r_addr) begin
                    n_h = erd_h; n_c = erd_c;
                    if (r_op == OP_CHECK) begin
                        n_state = (erd_c != '0) ? ST_TR_RD : ST_TR_CMP;
                    end else begin
                        n_state = ST_APPEND;
                    end
                end else if (r_e == E_LAST) begin
                    n_e = '0;
                    n_state = (r_op == OP_CHECK) ? ST_OUT : ST_FREE;
                end else begin
                    n_e = r_e + 1'b1;
                end
            end
            ST_TR_RD: n_state = ST_TR_CMP;
            ST_TR_CMP: begin
                if (r_c != '0 && old) begin
                    n_h = h_nx; n_c = r_c - 1'b1;
                    n_state = (r_c != CW'(1)) ? ST_TR_RD : ST_TR_CMP;
                end else begin
                    ewe = 1'b1;
                    ewd = {r_addr, r_h, r_c};
                    n_out = {1'b0, 5'(r_c), 1'b0, (32'(r_c) >= 32'(r_lim))};
                    n_state = ST_OUT;
                end
            end
            ST_FREE: begin
                if (!r_valid[r_e]) begin
                    n_valid[r_e] = 1'b1;
                    n_h = '0; n_c = '0;
                    n_state = ST_APPEND;
                end else if (r_e == E_LAST) begin
                    n_e = '0;
                    if (r_post) begin
                        n_state = ST_OUT;
                    end else begin
                        n_post = 1'b1;
                        n_state = ST_SW_ENT;
                    end
                end else begin
                    n_e = r_e + 1'b1;
                end
            end
            ST_APPEND: begin
                if (r_c >= C_MAX) begin
                    n_h = h_nx;
                    n_c = C_MAX;
                    waddr = {r_e, r_h};
                end else begin
                    n_c = r_c + 1'b1;
                end
                we = 1'b1;
                ewe = 1'b1;
                ewd = {r_addr, n_h, n_c};
                n_out = {1'b0, 5'(n_c), 1'b1, 1'b0};
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (m_axis_tready) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

`ifndef SYNTHESIS
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !m_axis_tvalid) else $error("ready while result pending");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1]))
        else $error("limited and tracked together");
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ewe |-> ewd[CW-1:0] <= C_MAX) else $error("ring count overflow");
`endif
endmodule
`default_nettype wire

// ----- dv/per_source_sliding_window_limiter_unit_tb.sv -----
// Self-checking testbench for the per-source sliding window request limiter.
`timescale 1ns / 1ps
`default_nettype none
module per_source_sliding_window_limiter_unit_tb;
    import psl_pkg::*;

    localparam int NSRC = 64;
    localparam int NREQ = 16;
    localparam int SWEEP_GAP = 1000;
    localparam int SETTLE_CYCLES = 3000;
    localparam int STALL_LIMIT = 20000;
    localparam int QDEPTH = 16;

    typedef struct packed {
        logic       limited;
        logic       tracked;
        logic [4:0] recent;
    } t_verdict;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic        i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = CFG_ENABLE;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    per_source_sliding_window_limiter_unit uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Shadow copy of the limiter state.
    logic        lim_en;
    logic [4:0]  lim_req;
    logic [30:0] win_ms;
    logic [31:0] src_tag [NSRC];
    logic        src_live [NSRC];
    logic [31:0] stamps [NSRC*NREQ];
    int          ring_hd [NSRC];
    int          ring_n [NSRC];
    logic [31:0] last_sweep;

    t_verdict    verdict_q [QDEPTH];
    int          q_wr = 0;
    int          q_rd = 0;
    int          errors = 0;
    bit          idle_on = 1'b1;
    int          rx_stall = 0;
    int          quiet_cycles = 0;
    logic [31:0] clock_ms = 32'd5000;
    logic [31:0] addr_pool [8];

    function automatic void trim_ring(int e, logic [31:0] now, logic [31:0] span);
        logic [31:0] age;
        while (ring_n[e] > 0) begin
            age = now - stamps[e*NREQ + ring_hd[e]];
            if (age <= span) break;
            ring_hd[e] = (ring_hd[e] + 1) % NREQ;
            ring_n[e] = ring_n[e] - 1;
        end
    endfunction

    function automatic void sweep_table(logic [31:0] now);
        logic [31:0] span;
        span = {win_ms, 1'b0};
        for (int e = 0; e < NSRC; e++) begin
            if (src_live[e]) begin
                trim_ring(e, now, span);
                if (ring_n[e] == 0) src_live[e] = 1'b0;
            end
        end
    endfunction

    function automatic int lookup_src(logic [31:0] addr);
        for (int e = 0; e < NSRC; e++)
            if (src_live[e] && src_tag[e] == addr) return e;
        return -1;
    endfunction

    function automatic int first_free();
        for (int e = 0; e < NSRC; e++)
            if (!src_live[e]) return e;
        return -1;
    endfunction

    function automatic t_verdict limiter_verdict(logic op, logic [31:0] addr,
                                                 logic present, logic [31:0] now);
        t_verdict v;
        int e;
        logic [31:0] gap;
        v = '0;
        if (lim_en && present) begin
            if (op == OP_CHECK) begin
                gap = now - last_sweep;
                if (gap >= SWEEP_GAP) begin
                    last_sweep = now;
                    sweep_table(now);
                end
                e = lookup_src(addr);
                if (e >= 0) begin
                    trim_ring(e, now, {1'b0, win_ms});
                    v.recent = ring_n[e][4:0];
                    v.limited = (ring_n[e] >= lim_req);
                end
            end else begin
                e = lookup_src(addr);
                if (e < 0) begin
                    e = first_free();
                    if (e < 0) begin
                        sweep_table(now);
                        e = first_free();
                    end
                    if (e >= 0) begin
                        src_live[e] = 1'b1;
                        src_tag[e] = addr;
                        ring_hd[e] = 0;
                        ring_n[e] = 0;
                    end
                end
                if (e >= 0) begin
                    if (ring_n[e] >= NREQ) begin
                        ring_hd[e] = (ring_hd[e] + 1) % NREQ;
                        ring_n[e] = NREQ - 1;
                    end
                    stamps[e*NREQ + (ring_hd[e] + ring_n[e]) % NREQ] = now;
                    ring_n[e] = ring_n[e] + 1;
                    v.tracked = 1'b1;
                    v.recent = ring_n[e][4:0];
                end
            end
        end
        return v;
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_ENABLE: lim_en = val[0];
            CFG_LIMIT:  lim_req = val[4:0];
            CFG_WINDOW: win_ms = val;
            default: ;
        endcase
    endtask

    task automatic set_policy(logic en, logic [4:0] lim, logic [30:0] win);
        wait (q_wr == q_rd);
        write_reg(CFG_ENABLE, {30'd0, en});
        write_reg(CFG_LIMIT, {26'd0, lim});
        write_reg(CFG_WINDOW, win);
    endtask

    task automatic await_drain();
        wait (q_wr == q_rd);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_word(logic op, logic [31:0] addr, logic present, logic [31:0] now);
        if (idle_on && $urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, 19)) @(negedge i_clk);
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {6'd0, now, present, addr, op};
        do @(posedge i_clk); while (!s_axis_tready);
        verdict_q[q_wr % QDEPTH] = limiter_verdict(op, addr, present, now);
        q_wr++;
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic tick_send(logic op, logic [31:0] addr, int step);
        clock_ms = clock_ms + step;
        send_word(op, addr, 1'b1, clock_ms);
    endtask

    task automatic test_disabled_after_reset();
        send_word(OP_RECORD, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
        send_word(OP_CHECK, 32'hFFFF_FFFF, 1'b1, 32'd0);
        send_word(OP_RECORD, 32'h0, 1'b1, 32'd2000);
    endtask

    task automatic test_directed();
        set_policy(1'b1, 5'd3, 31'd100);
        tick_send(OP_CHECK, 32'h0A00_0001, 0);
        repeat (3) tick_send(OP_RECORD, 32'h0A00_0001, 10);
        tick_send(OP_CHECK, 32'h0A00_0001, 1);
        send_word(OP_RECORD, 32'h0A00_0001, 1'b0, clock_ms);
        send_word(OP_CHECK, 32'h0A00_0001, 1'b0, clock_ms);
        tick_send(OP_CHECK, 32'h0A00_0001, 90);
        repeat (17) tick_send(OP_RECORD, 32'h0000_0000, 1);
        tick_send(OP_CHECK, 32'h0000_0000, 2);
        clock_ms = 32'hFFFF_FFA0;
        repeat (3) tick_send(OP_RECORD, 32'hFFFF_FFFF, 40);
        tick_send(OP_CHECK, 32'hFFFF_FFFF, 1500);
        await_drain();
        set_policy(1'b1, 5'd0, 31'h7FFF_FFFF);
        tick_send(OP_RECORD, 32'h5555_AAAA, 3);
        tick_send(OP_CHECK, 32'h5555_AAAA, 2000);
        tick_send(OP_CHECK, 32'h1234_5678, 1);
        await_drain();
        set_policy(1'b1, 5'd16, 31'd0);
        tick_send(OP_RECORD, 32'hAAAA_5555, 0);
        tick_send(OP_CHECK, 32'hAAAA_5555, 0);
        tick_send(OP_CHECK, 32'hAAAA_5555, 1);
        await_drain();
    endtask

    task automatic test_table_full();
        set_policy(1'b1, 5'd16, 31'd100);
        for (int i = 0; i < NSRC + 2; i++) tick_send(OP_RECORD, 32'h7000_0000 + i, 0);
        tick_send(OP_RECORD, 32'h7100_0000, 1);
        tick_send(OP_RECORD, 32'h7100_0001, 500);
        tick_send(OP_CHECK, 32'h7000_0003, 1);
        await_drain();
    endtask

    task automatic random_phase(int count, bit pause_once);
        logic [31:0] addr;
        int pick;
        for (int i = 0; i < 8; i++) addr_pool[i] = $urandom;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 19);
            if (pick < 15) addr = addr_pool[$urandom_range(0, 7)];
            else if (pick < 18) addr = 32'h6000_0000 + $urandom_range(0, 79);
            else addr = $urandom;
            pick = $urandom_range(0, 39);
            if (pick == 0) clock_ms = $urandom;
            else if (pick < 4) clock_ms = clock_ms + $urandom_range(500, 5000);
            else clock_ms = clock_ms + $urandom_range(0, 40);
            send_word(1'($urandom_range(0, 1)), addr, $urandom_range(0, 9) != 0, clock_ms);
            if (pause_once && n == count / 2) wait (q_wr == q_rd);
        end
        await_drain();
    endtask

    task automatic test_random();
        set_policy(1'b1, 5'd4, 31'd60);
        random_phase(110, 1'b1);
        set_policy(1'b1, 5'($urandom_range(0, 16)), 31'($urandom_range(1, 2000)));
        random_phase(110, 1'b0);
        set_policy(1'b0, 5'd16, 31'h7FFF_FFFF);
        random_phase(40, 1'b0);
        set_policy(1'b1, 5'd16, 31'h7FFF_FFFF);
        random_phase(60, 1'b0);
        set_policy(1'b1, 5'($urandom_range(1, 16)), 31'($urandom));
        random_phase(60, 1'b0);
        idle_on = 1'b0;
        set_policy(1'b1, 5'd2, 31'd30);
        random_phase(60, 1'b0);
    endtask

    always @(negedge i_clk) begin
        if (rx_stall > 0) begin
            rx_stall <= rx_stall - 1;
            m_axis_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            rx_stall <= $urandom_range(0, 18);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_verdict want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (q_wr == q_rd) begin
                errors++;
                if (errors <= 10) $display("Unexpected result word %h", m_axis_tdata);
            end else begin
                want = verdict_q[q_rd % QDEPTH];
                q_rd++;
                if (m_axis_tdata[0] !== want.limited || m_axis_tdata[1] !== want.tracked ||
                    m_axis_tdata[6:2] !== want.recent) begin
                    errors++;
                    if (errors <= 10)
                        $display("Mismatch: expected %b %b %0d, got %b %b %0d",
                                 want.limited, want.tracked, want.recent,
                                 m_axis_tdata[0], m_axis_tdata[1], m_axis_tdata[6:2]);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        lim_en = 1'b0;
        lim_req = 5'd10;
        win_ms = 31'd60000;
        last_sweep = '0;
        for (int e = 0; e < NSRC; e++) begin
            src_live[e] = 1'b0;
            ring_hd[e] = 0;
            ring_n[e] = 0;
        end
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_disabled_after_reset();
        test_directed();
        test_table_full();
        test_random();
        wait (q_wr == q_rd);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (errors == 0 && q_wr == q_rd) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
`default_nettype wire
